// ===== rtl/llf_pkg.sv =====
package llf_pkg;

    // Default sizes of the stores
    localparam int DEF_MAX_INPUTS  = 64;
    localparam int DEF_MAX_OUTPUTS = 16;

    // Field and register widths
    localparam int OP_W      = 2;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 6;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 32;
    localparam int LEN_IN_W  = 7;
    localparam int LEN_OUT_W = 5;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Register reset values
    localparam logic [LEN_IN_W-1:0]  RST_INPUT_LENGTH  = 7'd64;
    localparam logic [LEN_OUT_W-1:0] RST_OUTPUT_LENGTH = 5'd16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
    localparam logic [OP_W-1:0] OP_ELEM   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 1'b1;

    // Work kinds passed from the front end to the back end
    typedef enum logic [1:0] {
        K_WEIGHT,
        K_BIAS,
        K_ELEM
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
        logic                     adds;   // element lies inside the active length
        logic                     last;
    } t_job;

    // Back end sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/llf_front.sv =====
module llf_front #(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_OUTPUTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [llf_pkg::OP_W-1:0]      i_operation,
    input  logic [llf_pkg::ROW_W-1:0]     i_row,
    input  logic [llf_pkg::COL_W-1:0]     i_column,
    input  logic signed [llf_pkg::VAL_W-1:0] i_value,
    input  logic                          i_last,
    input  logic [llf_pkg::LEN_IN_W-1:0]  i_in_len,
    output logic                          o_busy,
    output logic                          o_job_valid,
    output llf_pkg::t_job                 o_job,
    input  logic                          i_job_pop
);
    import llf_pkg::*;

    t_job       job_in;
    logic       keep;
    logic       push;
    t_job       r_fifo [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;

    // Classify the item: drop unused codes and out-of-range writes
    always_comb begin
        job_in.kind  = K_ELEM;
        job_in.row   = i_row;
        job_in.col   = i_column;
        job_in.value = i_value;
        job_in.last  = i_last;
        job_in.adds  = (32'(i_column) < 32'(i_in_len)) && (32'(i_column) < MAX_INPUTS);
        keep         = 1'b0;
        unique case (i_operation)
            OP_WEIGHT: begin
                job_in.kind = K_WEIGHT;
                keep = (32'(i_row) < MAX_OUTPUTS) && (32'(i_column) < MAX_INPUTS);
            end
            OP_BIAS: begin
                job_in.kind = K_BIAS;
                keep = (32'(i_row) < MAX_OUTPUTS);
            end
            OP_ELEM: begin
                keep = job_in.adds || i_last;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_busy      = (r_count == 2'd2);
    assign push        = i_start && !o_busy && keep;
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_fifo[r_rptr];

    // Two-entry queue towards the back end
    always_comb begin
        n_count = r_count;
        if (push && !i_job_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_job_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_job_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= job_in;
        end
    end

endmodule

// ===== rtl/llf_back.sv =====
module llf_back #(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_OUTPUTS = 16,
    localparam int RCW = $clog2(MAX_OUTPUTS + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [RCW-1:0]                   i_nrows,
    input  logic                             i_job_valid,
    input  llf_pkg::t_job                    i_job,
    output logic                             o_job_pop,
    output logic                             o_valid,
    output logic [llf_pkg::ROW_W-1:0]        o_out_row,
    output logic signed [llf_pkg::VAL_W-1:0] o_out_value,
    output logic                             o_out_last
);
    import llf_pkg::*;

    localparam int WDEPTH = MAX_OUTPUTS * MAX_INPUTS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int RW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    t_state r_state, n_state;

    logic [RCW-1:0]          r_cnt;
    logic [WAW-1:0]          r_addr;
    logic signed [VAL_W-1:0] r_x;
    logic                    r_last;
    logic                    mac_issue, emit_issue, cnt_end, pipe_busy;
    logic                    sum_clr;
    logic [WAW-1:0]          wr_addr;

    // Stores
    logic signed [VAL_W-1:0] r_wmem [WDEPTH];
    logic signed [VAL_W-1:0] r_bias [MAX_OUTPUTS];
    logic signed [SUM_W-1:0] r_sums [MAX_OUTPUTS];

    // Multiply-accumulate pipeline
    logic                    r_s1_v, r_s2_v;
    logic [RW-1:0]           r_s1_row, r_s2_row;
    logic signed [VAL_W-1:0] r_wdat, r_s1_x;
    logic signed [SUM_W-1:0] r_prod;
    logic [RW-1:0]           sum_idx;
    logic signed [SUM_W-1:0] sum_rd, acc;
    logic signed [SUM_W:0]   acc_wide;

    // Result stage
    logic                    r_e_v, r_e_last;
    logic [RW-1:0]           r_e_row;
    logic signed [SUM_W-1:0] r_e_sum;
    logic signed [VAL_W-1:0] r_e_bias;
    logic signed [33:0]      fin_t;
    logic signed [25:0]      fin_q;
    logic signed [VAL_W-1:0] fin_v;

    logic                    r_out_valid, r_out_last;
    logic [ROW_W-1:0]        r_out_row;
    logic signed [VAL_W-1:0] r_out_value;

    assign pipe_busy = r_s1_v || r_s2_v;
    assign cnt_end   = (r_cnt == (i_nrows - RCW'(1)));
    assign wr_addr   = WAW'(32'(i_job.row) * MAX_INPUTS + 32'(i_job.col));

    // Sequencer outputs
    always_comb begin
        o_job_pop  = (r_state == S_IDLE) && i_job_valid;
        mac_issue  = (r_state == S_MAC);
        emit_issue = (r_state == S_EMIT) && !pipe_busy;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_job_pop && i_job.kind == K_ELEM && i_nrows != '0) begin
                    if (i_job.adds) begin
                        n_state = S_MAC;
                    end else if (i_job.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MAC: begin
                if (cnt_end) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (emit_issue && cnt_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_e_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s1_v      <= mac_issue;
            r_s2_v      <= r_s1_v;
            r_e_v       <= emit_issue;
            r_out_valid <= r_e_v;
            if (mac_issue || emit_issue) begin
                r_cnt <= cnt_end ? '0 : r_cnt + RCW'(1);
            end
        end
    end

    // Element operand and weight address walk, one row per cycle
    always_ff @(posedge i_clk) begin
        if (o_job_pop && i_job.kind == K_ELEM) begin
            r_x    <= i_job.value;
            r_last <= i_job.last;
            r_addr <= WAW'(i_job.col);
        end else if (mac_issue) begin
            r_addr <= r_addr + WAW'(MAX_INPUTS);
        end
    end

    // Weight memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (o_job_pop && i_job.kind == K_WEIGHT) begin
            r_wmem[wr_addr] <= i_job.value;
        end
        if (mac_issue) begin
            r_wdat <= r_wmem[r_addr];
        end
    end

    // Bias words
    always_ff @(posedge i_clk) begin
        if (o_job_pop && i_job.kind == K_BIAS) begin
            r_bias[RW'(i_job.row)] <= i_job.value;
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        r_s1_row <= r_cnt[RW-1:0];
        r_s1_x   <= r_x;
        r_s2_row <= r_s1_row;
        r_prod   <= r_wdat * r_s1_x;
    end

    // Row sum read port, shared by accumulate and result readout
    assign sum_idx = r_s2_v ? r_s2_row : r_cnt[RW-1:0];
    assign sum_rd  = r_sums[sum_idx];

    // Saturating accumulate
    always_comb begin
        acc_wide = 33'(sum_rd) + 33'(r_prod);
        if (acc_wide > 33'sd2147483647) begin
            acc = 32'sh7FFF_FFFF;
        end else if (acc_wide < -33'sd2147483648) begin
            acc = 32'sh8000_0000;
        end else begin
            acc = acc_wide[SUM_W-1:0];
        end
    end

    // Every row sum clears at the end of a vector, even with no active rows
    assign sum_clr = (emit_issue && cnt_end)
                  || (o_job_pop && i_job.kind == K_ELEM && i_job.last && i_nrows == '0);

    // Row sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_OUTPUTS; i++) begin
                r_sums[i] <= '0;
            end
        end else if (r_s2_v) begin
            r_sums[r_s2_row] <= acc;
        end else if (sum_clr) begin
            for (int i = 0; i < MAX_OUTPUTS; i++) begin
                r_sums[i] <= '0;
            end
        end
    end

    // Result read stage
    always_ff @(posedge i_clk) begin
        if (emit_issue) begin
            r_e_sum  <= sum_rd;
            r_e_bias <= r_bias[r_cnt[RW-1:0]];
            r_e_row  <= r_cnt[RW-1:0];
            r_e_last <= cnt_end;
        end
    end

    // Bias add, round half up, saturate to Q8.8
    always_comb begin
        fin_t = 34'(r_e_sum) + 34'(signed'({r_e_bias, 8'h00})) + 34'sd128;
        fin_q = fin_t[33:8];
        if (fin_q > 26'sd32767) begin
            fin_v = 16'sh7FFF;
        end else if (fin_q < -26'sd32768) begin
            fin_v = 16'sh8000;
        end else begin
            fin_v = fin_q[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row   <= ROW_W'(r_e_row);
        r_out_value <= fin_v;
        r_out_last  <= r_e_last;
    end

    assign o_valid     = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/linear_layer_forward.sv =====
// Fully connected layer, forward pass, y = W*x + b in signed Q8.8. Weight and
// bias items load the stores; element items inside the input length are
// multiplied into every active row sum, and an element marked last makes
// the block emit one result per active row, rows in order on consecutive
// cycles, the final one flagged by o_out_last. Results cannot be held off:
// o_valid is high for one cycle per result. Items enter a two-item queue and
// busy is high while it is full. The back end writes a weight or bias item
// straight into its store and walks an element one row per cycle through
// the single multiplier and the one read port of the weight memory, taking
// no new item meanwhile; an element marked last then waits for the multiply
// pipeline to drain and emits its results. A result passes the result read
// stage and the output register after its row is read out.
module linear_layer_forward #(
    parameter int MAX_INPUTS  = llf_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = llf_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [llf_pkg::OP_W-1:0]         i_operation,
    input  logic [llf_pkg::ROW_W-1:0]        i_row,
    input  logic [llf_pkg::COL_W-1:0]        i_column,
    input  logic signed [llf_pkg::VAL_W-1:0] i_value,
    input  logic                             i_last,
    input  logic                             i_cfg_we,
    input  logic [llf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [llf_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                             o_valid,
    output logic [llf_pkg::ROW_W-1:0]        o_out_row,
    output logic signed [llf_pkg::VAL_W-1:0] o_out_value,
    output logic                             o_out_last
);
    import llf_pkg::*;

    localparam int RCW = $clog2(MAX_OUTPUTS + 1);

    logic [LEN_IN_W-1:0]  r_input_length;
    logic [LEN_OUT_W-1:0] r_output_length;
    logic [RCW-1:0]       eff_rows;
    logic                 job_valid, job_pop;
    t_job                 job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_length  <= RST_INPUT_LENGTH;
            r_output_length <= RST_OUTPUT_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INPUT_LENGTH:  r_input_length  <= i_cfg_data[LEN_IN_W-1:0];
                REG_OUTPUT_LENGTH: r_output_length <= i_cfg_data[LEN_OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Active row count, capped at the store depth
    always_comb begin
        if (32'(r_output_length) > MAX_OUTPUTS) begin
            eff_rows = RCW'(MAX_OUTPUTS);
        end else begin
            eff_rows = RCW'(r_output_length);
        end
    end

    llf_front #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_in_len    (r_input_length),
        .o_busy      (busy),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    llf_back #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nrows     (eff_rows),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

endmodule

// ===== rtl/llf_checker.sv =====
module llf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      busy,
    input logic                      o_valid,
    input logic [llf_pkg::ROW_W-1:0] o_out_row,
    input logic                      o_out_last
);

    // Rows of one vector come out back to back
    a_rows_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_last |=> o_valid)
        else $error("result burst broken before final row");

    // Rows count up by one within a burst
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_last |=> o_out_row == $past(o_out_row) + 1'b1)
        else $error("row index did not step by one");

    // A burst starts at row zero
    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid) |-> o_out_row == '0)
        else $error("result burst did not start at row zero");

    // Final row closes the burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |=> !o_valid)
        else $error("result after final row");

    // Nothing pending straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("activity right after reset");

endmodule

bind linear_layer_forward llf_checker u_llf_checker (.*);

// ===== test/layer_output_checker.sv =====
module layer_output_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [llf_pkg::OP_W-1:0]         i_operation,
    input  logic [llf_pkg::ROW_W-1:0]        i_row,
    input  logic [llf_pkg::COL_W-1:0]        i_column,
    input  logic signed [llf_pkg::VAL_W-1:0] i_value,
    input  logic                             i_last,
    input  logic                             i_cfg_we,
    input  logic [llf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [llf_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             o_valid,
    input  logic [llf_pkg::ROW_W-1:0]        o_out_row,
    input  logic signed [llf_pkg::VAL_W-1:0] o_out_value,
    input  logic                             o_out_last,
    output int                               n_fail,
    output int                               n_pending
);
    import llf_pkg::*;

    localparam longint SUM_MAX    = 64'sd2147483647;
    localparam longint SUM_MIN    = -64'sd2147483648;

    typedef struct {
        logic [ROW_W-1:0]        row;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_row_result;

    // predicted layer state
    logic signed [VAL_W-1:0] weight_mem [DEF_MAX_OUTPUTS][DEF_MAX_INPUTS];
    logic signed [VAL_W-1:0] bias_mem [DEF_MAX_OUTPUTS];
    logic signed [SUM_W-1:0] row_sum [DEF_MAX_OUTPUTS];
    logic [LEN_IN_W-1:0]     input_length;
    logic [LEN_OUT_W-1:0]    output_length;
    t_row_result             expected_rows [$];
    int                      fails;

    function automatic logic signed [SUM_W-1:0] clamp_sum(longint s);
        if (s > SUM_MAX)
            return SUM_W'(SUM_MAX);
        if (s < SUM_MIN)
            return SUM_W'(SUM_MIN);
        return SUM_W'(s);
    endfunction

    // sum plus bias, round half up to Q8.8, clamp to 16 bits
    function automatic logic signed [VAL_W-1:0] round_row(logic signed [SUM_W-1:0] sum,
                                                          logic signed [VAL_W-1:0] bias);
        longint t;
        t = longint'(sum) + longint'(bias) * 256 + 128;
        t = t >>> 8;
        if (t > 32767)
            return 16'sh7fff;
        if (t < -32768)
            return 16'sh8000;
        return VAL_W'(t);
    endfunction

    // one accepted item: store writes, or accumulate and maybe emit a vector
    function automatic void advance_layer(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                          logic [COL_W-1:0] col,
                                          logic signed [VAL_W-1:0] val, logic last);
        int          rows;
        int          cols;
        t_row_result res;
        rows = (output_length > DEF_MAX_OUTPUTS) ? DEF_MAX_OUTPUTS : int'(output_length);
        cols = (input_length > DEF_MAX_INPUTS) ? DEF_MAX_INPUTS : int'(input_length);
        case (op)
            OP_WEIGHT: weight_mem[row][col] = val;
            OP_BIAS:   bias_mem[row] = val;
            OP_ELEM: begin
                if (int'(col) < cols) begin
                    for (int r = 0; r < rows; r++)
                        row_sum[r] = clamp_sum(longint'(row_sum[r])
                                               + longint'(weight_mem[r][col]) * longint'(val));
                end
                if (last) begin
                    for (int r = 0; r < rows; r++) begin
                        res.row   = ROW_W'(r);
                        res.value = round_row(row_sum[r], bias_mem[r]);
                        res.last  = (r == rows - 1);
                        expected_rows.push_back(res);
                    end
                    for (int r = 0; r < DEF_MAX_OUTPUTS; r++)
                        row_sum[r] = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void flag_mismatch(string what, int want, int got);
        fails++;
        $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // compare results first, so an item taken on this edge cannot match itself
    always @(posedge i_clk) begin
        t_row_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < DEF_MAX_OUTPUTS; r++)
                row_sum[r] = '0;
            input_length  = RST_INPUT_LENGTH;
            output_length = RST_OUTPUT_LENGTH;
            expected_rows.delete();
            fails = 0;
        end else begin
            if (o_valid) begin
                if (expected_rows.size() == 0) begin
                    fails++;
                    $display("%0t unexpected result: expected none, got row %0d value %0d",
                             $time, o_out_row, o_out_value);
                end else begin
                    want = expected_rows.pop_front();
                    if (o_out_row !== want.row)
                        flag_mismatch("out_row", int'(want.row), int'(o_out_row));
                    if (o_out_value !== want.value)
                        flag_mismatch("out_value", int'(want.value), int'(o_out_value));
                    if (o_out_last !== want.last)
                        flag_mismatch("out_last", int'(want.last), int'(o_out_last));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_INPUT_LENGTH)
                    input_length = i_cfg_data[LEN_IN_W-1:0];
                else if (i_cfg_index == REG_OUTPUT_LENGTH)
                    output_length = i_cfg_data[LEN_OUT_W-1:0];
            end
            if (start && !busy)
                advance_layer(i_operation, i_row, i_column, i_value, i_last);
        end
        n_fail    <= fails;
        n_pending <= expected_rows.size();
    end

endmodule

// ===== test/testbench.sv =====
module testbench;
    import llf_pkg::*;

    localparam int               CYCLE_LIMIT   = 300000;
    localparam int               SETTLE_CYCLES = 64;
    localparam int               RANDOM_ITEMS  = 170;
    localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [OP_W-1:0]         i_operation = '0;
    logic [ROW_W-1:0]        i_row = '0;
    logic [COL_W-1:0]        i_column = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    i_last = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    o_valid;
    logic [ROW_W-1:0]        o_out_row;
    logic signed [VAL_W-1:0] o_out_value;
    logic                    o_out_last;
    int                      n_fail;
    int                      n_pending;
    int                      cycle_count = 0;

    // stimulus bookkeeping: which store entries hold a value, active sizes
    bit weight_loaded [DEF_MAX_OUTPUTS][DEF_MAX_INPUTS];
    bit bias_loaded [DEF_MAX_OUTPUTS];
    int active_in;
    int active_out;
    int idle_odds;
    int items_sent;

    linear_layer_forward u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

    layer_output_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last),
        .n_fail      (n_fail),
        .n_pending   (n_pending)
    );

    always #4 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("linear_layer_forward regression: fail");
            $finish;
        end
    end

    // extremes often, otherwise any 16-bit pattern
    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // one item through the start/busy handshake; entered and left at a falling edge
    task automatic issue(input logic [OP_W-1:0] op, input int row, input int col,
                         input logic signed [VAL_W-1:0] val, input logic last);
        if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
            start = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_operation = op;
        i_row       = ROW_W'(row);
        i_column    = COL_W'(col);
        i_value     = val;
        i_last      = last;
        start       = 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
        if (op == OP_WEIGHT)
            weight_loaded[row % DEF_MAX_OUTPUTS][col % DEF_MAX_INPUTS] = 1'b1;
        else if (op == OP_BIAS)
            bias_loaded[row % DEF_MAX_OUTPUTS] = 1'b1;
        items_sent++;
    endtask

    // block idle: no results owed, and time for any element still in flight
    task automatic settle();
        start = 1'b0;
        wait (n_pending == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_lengths(input int in_len, input int out_len);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_index = REG_INPUT_LENGTH;
        i_cfg_data  = CFG_W'(in_len);
        @(negedge i_clk);
        i_cfg_index = REG_OUTPUT_LENGTH;
        i_cfg_data  = CFG_W'(out_len);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_data  = CFG_W'($urandom);
        active_in   = (in_len % 128 > DEF_MAX_INPUTS) ? DEF_MAX_INPUTS : in_len % 128;
        active_out  = (out_len % 32 > DEF_MAX_OUTPUTS) ? DEF_MAX_OUTPUTS : out_len % 32;
    endtask

    // element item; loads any weight or bias it would read that holds no value yet
    task automatic feed_element(input int col, input logic signed [VAL_W-1:0] val,
                                input logic last);
        if (col < active_in) begin
            for (int r = 0; r < active_out; r++)
                if (!weight_loaded[r][col])
                    issue(OP_WEIGHT, r, col, rand_value(), 1'($urandom));
        end
        if (last) begin
            for (int r = 0; r < active_out; r++)
                if (!bias_loaded[r])
                    issue(OP_BIAS, r, $urandom_range(0, 63), rand_value(), 1'($urandom));
        end
        issue(OP_ELEM, $urandom_range(0, 15), col, val, last);
    endtask

    // stray item between elements: unused operation or a store overwrite
    task automatic noise_item();
        case ($urandom_range(0, 2))
            0: issue(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 63), rand_value(),
                     1'($urandom));
            1: issue(OP_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 63), rand_value(),
                     1'($urandom));
            default: issue(OP_BIAS, $urandom_range(0, 15), $urandom_range(0, 63),
                           rand_value(), 1'($urandom));
        endcase
    endtask

    // a vector of a few elements, mostly in range, closed by a last element
    task automatic random_vector();
        int n_elems;
        int col;
        n_elems = $urandom_range(1, 6);
        for (int k = 0; k < n_elems; k++) begin
            if ($urandom_range(0, 5) == 0)
                noise_item();
            if (active_in == 0 || (active_in < DEF_MAX_INPUTS && $urandom_range(0, 7) == 0))
                col = $urandom_range(active_in, 63);
            else
                col = $urandom_range(0, active_in - 1);
            feed_element(col, rand_value(), k == n_elems - 1);
        end
    endtask

    initial begin
        int rand_base;
        int phase_end;
        int phase;
        idle_odds  = 4;
        items_sent = 0;
        active_in  = DEF_MAX_INPUTS;
        active_out = DEF_MAX_OUTPUTS;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: four columns, two rows
        set_lengths(4, 2);
        issue(OP_WEIGHT, 0, 0, 16'sh8000, 1'b0);
        issue(OP_WEIGHT, 1, 0, 16'sh7fff, 1'b1);
        issue(OP_WEIGHT, 0, 1, 16'sh0001, 1'b0);
        issue(OP_WEIGHT, 1, 1, 16'shffff, 1'b1);
        issue(OP_BIAS, 0, 0, 16'sh7fff, 1'b1);
        issue(OP_BIAS, 1, 63, 16'sh8000, 1'b0);
        issue(OP_UNUSED, 15, 63, 16'shffff, 1'b1);
        // three max products overflow both sums; last element lies past the length
        feed_element(0, 16'sh8000, 1'b0);
        feed_element(0, 16'sh8000, 1'b0);
        feed_element(0, 16'sh8000, 1'b0);
        feed_element(5, 16'sh7fff, 1'b1);
        // half-LSB ties and just below zero, with zero bias
        issue(OP_BIAS, 0, 0, 16'sh0000, 1'b0);
        issue(OP_BIAS, 1, 0, 16'sh0000, 1'b0);
        feed_element(1, 16'sh0080, 1'b1);
        feed_element(1, -16'sh0081, 1'b1);
        // zero lengths: nothing adds and a last element emits nothing
        set_lengths(0, 0);
        feed_element(0, 16'sh0064, 1'b0);
        feed_element(63, 16'sh0005, 1'b1);
        // out-of-range lengths clamp to the store sizes
        set_lengths(127, 31);
        feed_element(63, 16'sh7fff, 1'b1);

        // random phases, each with its own lengths and idling
        rand_base = items_sent;
        phase     = 0;
        while (items_sent - rand_base < RANDOM_ITEMS) begin
            case (phase)
                0: set_lengths(64, 16);
                1: set_lengths(1, 1);
                2: set_lengths(2, 0);
                3: set_lengths(100, 20);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_lengths($urandom_range(0, 127), $urandom_range(0, 31));
                    else
                        set_lengths($urandom_range(1, 8), $urandom_range(1, 6));
                end
            endcase
            idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 5);
            phase_end = items_sent + 30;
            while (items_sent < phase_end && items_sent - rand_base < RANDOM_ITEMS) begin
                if (items_sent - rand_base > RANDOM_ITEMS - 40)
                    idle_odds = 0;
                random_vector();
            end
            phase++;
        end

        // drain
        start = 1'b0;
        wait (n_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("linear_layer_forward regression: pass");
        else
            $display("linear_layer_forward regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/llf_pkg.sv
rtl/llf_front.sv
rtl/llf_back.sv
rtl/linear_layer_forward.sv
rtl/llf_checker.sv
test/layer_output_checker.sv
test/testbench.sv
